### design/skx_pkg.sv
// Package: seeds, SHA-1 constants, shared types and helper functions.
`default_nettype none
package skx_pkg;

    localparam int BLK_BYTES = 20;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [159:0] SEED_A =
        160'h8DE5A856_D2EE76E0_6C45DD9F_5712C63A_0ADB05C1;
    localparam logic [159:0] SEED_B =
        160'hAF808FC3_977B2187_752269DE_83CCA6C6_12F0DC49;

    localparam logic [159:0] SHA1_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    // Item passed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        rotl1 = {x[30:0], x[31]};
    endfunction

    function automatic logic [31:0] rotl5(input logic [31:0] x);
        rotl5 = {x[26:0], x[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] x);
        rotl30 = {x[1:0], x[31:2]};
    endfunction

    // 16-word message for block || SEED_B with padding for 320 bits
    function automatic logic [511:0] build_msg(input logic [159:0] blk);
        build_msg = {blk, SEED_B, 32'h80000000, 128'h0, 32'h00000140};
    endfunction

endpackage
`default_nettype wire

### design/skx_front.sv
// Front end: accepts input bytes into a short queue.
`default_nettype none
module skx_front
    import skx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire logic       in_valid,
    output logic            in_ready,
    output item_t           q_item,
    output logic            q_valid,
    input  wire logic       q_ready
);

    item_t      mem_reg [QUEUE_DEPTH];
    logic       wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Pointer and count update
    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= '{data_byte: data_byte, last_byte: last_byte};
        end
    end

endmodule
`default_nettype wire

### design/skx_sha1.sv
// Iterative SHA-1 core: one round per cycle over a single padded block.
`default_nettype none
module skx_sha1
    import skx_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [159:0] blk_in,
    output logic              busy,
    output logic              done,
    output logic [159:0]      digest
);

    logic [511:0] w_reg, w_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    logic [6:0]   rnd_reg, rnd_next;
    logic         busy_reg, busy_next, done_reg, done_next;
    logic [31:0]  f, k, wt, wnew;

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign digest = {a_reg + SHA1_IV[159:128], b_reg + SHA1_IV[127:96],
                     c_reg + SHA1_IV[95:64], d_reg + SHA1_IV[63:32],
                     e_reg + SHA1_IV[31:0]};

    // Round function and message schedule
    always_comb
    begin
        wt   = w_reg[511:480];
        wnew = rotl1(w_reg[95:64] ^ w_reg[255:224] ^ w_reg[447:416] ^ w_reg[511:480]);
        if (rnd_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = 32'h5A827999;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'h6ED9EBA1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = 32'h8F1BBCDC;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'hCA62C1D6;
        end

        w_next    = w_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        d_next    = d_reg;
        e_next    = e_reg;
        rnd_next  = rnd_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            w_next    = build_msg(blk_in);
            {a_next, b_next, c_next, d_next, e_next} = SHA1_IV;
            rnd_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            a_next   = rotl5(a_reg) + f + e_reg + k + wt;
            b_next   = a_reg;
            c_next   = rotl30(b_reg);
            d_next   = c_reg;
            e_next   = d_reg;
            w_next   = {w_reg[479:0], wnew};
            rnd_next = rnd_reg + 7'd1;
            if (rnd_reg == 7'd79)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            rnd_reg  <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
    end

endmodule
`default_nettype wire

### design/skx_back.sv
// Back end: keystream state, XOR and output register; drives the hash core.
`default_nettype none
module skx_back
    import skx_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire item_t q_item,
    input  wire logic  q_valid,
    output logic       q_ready,
    output logic [7:0] out_byte,
    output logic       out_valid,
    input  wire logic  out_ready
);

    localparam logic [1:0] ST_INIT = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HASH = 2'd2;

    logic [1:0]   state_reg, state_next;
    logic [159:0] ks_reg, ks_next;
    logic [159:0] first_reg, first_next;
    logic [4:0]   pos_reg, pos_next;
    logic [7:0]   ob_reg, ob_next;
    logic         ov_reg, ov_next;
    logic         start;
    logic [159:0] hash_in;
    logic         h_busy, h_done;
    logic [159:0] digest;
    logic [7:0]   ks_byte;
    logic         take;

    skx_sha1 u_sha1 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .blk_in (hash_in),
        .busy   (h_busy),
        .done   (h_done),
        .digest (digest)
    );

    assign out_byte  = ob_reg;
    assign out_valid = ov_reg;
    assign ks_byte   = ks_reg[8'(159 - 8 * pos_reg) -: 8];
    assign q_ready   = (state_reg == ST_RUN) && (!ov_reg || out_ready);
    assign take      = q_valid && q_ready;

    // Sequencer: first block after reset, then one byte per transfer
    always_comb
    begin
        state_next = state_reg;
        ks_next    = ks_reg;
        first_next = first_reg;
        pos_next   = pos_reg;
        ob_next    = ob_reg;
        ov_next    = ov_reg && !out_ready;
        start      = 1'b0;
        hash_in    = ks_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                hash_in = SEED_A;
                start   = !h_busy && !h_done;
                if (h_done)
                begin
                    first_next = digest;
                    ks_next    = digest;
                    pos_next   = 5'd0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (take)
                begin
                    ob_next = q_item.data_byte ^ ks_byte;
                    ov_next = 1'b1;
                    if (q_item.last_byte)
                    begin
                        ks_next  = first_reg;
                        pos_next = 5'd0;
                    end
                    else if (pos_reg == 5'(BLK_BYTES - 1))
                    begin
                        pos_next   = 5'd0;
                        start      = 1'b1;
                        state_next = ST_HASH;
                    end
                    else
                    begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
            end
            ST_HASH:
            begin
                if (h_done)
                begin
                    ks_next    = digest;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            pos_reg   <= 5'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ks_reg    <= ks_next;
        first_reg <= first_next;
        ob_reg    <= ob_next;
    end

endmodule
`default_nettype wire

### design/sha1_chained_keystream_xor_top.sv
// Top level of the SHA-1 output-feedback keystream XOR block.
// Each transferred byte is XORed with the current 20-byte SHA-1 keystream block
// and is registered first in the two-entry queue and then in the output register.
// Within a block a byte is taken every cycle while the output is not stalled;
// after the twentieth byte the iterative SHA-1 core, one round per cycle,
// computes the next block, and no byte is taken until its result is loaded.
// After reset the core first makes the opening block before any byte is taken;
// a byte marked last returns to that stored opening block at once. Input bytes
// land in a two-entry queue, which absorbs up to two bytes while the hash runs;
// after that the input stalls until the next block is ready.
`default_nettype none
module sha1_chained_keystream_xor_top
    import skx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic [7:0]      out_byte,
    output logic            out_valid,
    input  wire logic       out_ready
);

    item_t q_item;
    logic  q_valid, q_ready;

    skx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_ready   (q_ready)
    );

    skx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .out_byte  (out_byte),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule
`default_nettype wire

### dv/skx_checker.sv
// Checker: watches both channels, predicts each output byte and compares it.
`timescale 1ns / 100ps
`default_nettype none
module skx_checker
    import skx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic [7:0] out_byte,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    output int              fail_count,
    output int              pending_count
);

    logic [159:0] opening_ks;
    logic [159:0] current_ks;
    int           ks_pos;
    logic [7:0]   expected_bytes[$];

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        rol = (x << n) | (x >> (32 - n));
    endfunction

    // SHA-1 over the 40-byte message blk || SEED_B, single padded block
    function automatic logic [159:0] digest_with_seed_b(input logic [159:0] blk);
        logic [511:0] msg;
        logic [31:0]  w[80];
        logic [31:0]  a, b, c, d, e, f, k, t;
        msg = {blk, SEED_B, 32'h80000000, 128'h0, 32'h00000140};
        for (int i = 0; i < 16; i++)
            w[i] = msg[511 - 32*i -: 32];
        for (int i = 16; i < 80; i++)
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        {a, b, c, d, e} = SHA1_IV;
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        digest_with_seed_b = {SHA1_IV[159:128] + a, SHA1_IV[127:96] + b,
                              SHA1_IV[95:64] + c, SHA1_IV[63:32] + d,
                              SHA1_IV[31:0] + e};
    endfunction

    initial
    begin
        opening_ks = digest_with_seed_b(SEED_A);
        current_ks = opening_ks;
        ks_pos     = 0;
        fail_count = 0;
    end

    assign pending_count = expected_bytes.size();

    always @(posedge clk)
    begin
        logic [7:0] exp_b;
        if (rst_n)
        begin
            // input transfer: predict, then advance the keystream
            if (in_valid && in_ready)
            begin
                expected_bytes.push_back(data_byte ^ current_ks[159 - 8*ks_pos -: 8]);
                if (last_byte)
                begin
                    current_ks = opening_ks;
                    ks_pos     = 0;
                end
                else if (ks_pos == BLK_BYTES - 1)
                begin
                    current_ks = digest_with_seed_b(current_ks);
                    ks_pos     = 0;
                end
                else
                    ks_pos++;
            end
            // output transfer: compare with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("out_byte: unexpected transfer, actual %02h", out_byte);
                    fail_count++;
                end
                else
                begin
                    exp_b = expected_bytes.pop_front();
                    if (out_byte !== exp_b)
                    begin
                        $error("out_byte: expected %02h actual %02h", exp_b, out_byte);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

### dv/tb.sv
// Testbench top: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import skx_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic       clk;
    logic       rst_n;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_ready;
    int         fail_count;
    int         pending_count;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         hold_cycles;
    int         quiet_cycles;

    sha1_chained_keystream_xor_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_byte  (out_byte),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    skx_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .out_byte      (out_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = 8'h00;
        last_byte     = 1'b0;
        out_ready     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready   <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // offer one byte, optionally idling first, and wait for its transfer
    task automatic send_byte(input logic [7:0] val, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= val;
        last_byte <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // buffer of random length; lengths straddle block boundaries
    task automatic send_buffer(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), i == len - 1);
    endtask

    task automatic random_phase(input int n_bytes);
        int sent;
        int len;
        sent = 0;
        while (sent < n_bytes)
        begin
            case ($urandom_range(3))
                0: len = $urandom_range(1, 3);
                1: len = $urandom_range(19, 21);
                2: len = $urandom_range(39, 61);
                default: len = $urandom_range(1, 25);
            endcase
            send_buffer(len);
            sent += len;
        end
    endtask

    initial
    begin
        quiet_cycles = 0;
        @(posedge rst_n);
        @(posedge clk);

        // directed: extremes, single- and two-byte buffers, a full block plus one
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        for (int i = 0; i < 21; i++)
            send_byte(i[0] ? 8'hA5 : 8'h5A, i == 20);

        // long receiver hold-off while bytes keep coming
        hold_cycles <= 400;
        random_phase(60);

        send_idle_pct = 17; recv_idle_pct = 79;
        random_phase(200);
        send_idle_pct = 79; recv_idle_pct = 17;
        random_phase(200);
        send_idle_pct = 0;  recv_idle_pct = 0;
        random_phase(190);
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire

### sha1_chained_keystream_xor_top.f
design/skx_pkg.sv
design/skx_front.sv
design/skx_sha1.sv
design/skx_back.sv
design/sha1_chained_keystream_xor_top.sv
dv/skx_checker.sv
dv/tb.sv
